FILE: rtl/gauge_needle_stepper_control_assert.svh
// ----------------------------------------------------------------------------
// Gauge needle stepper control assertion macros
// Shared concurrent assertion forms, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUGE_NEEDLE_STEPPER_CONTROL_ASSERT_SVH
`define GAUGE_NEEDLE_STEPPER_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GNSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gnsc_pkg.sv
// ----------------------------------------------------------------------------
// Gauge needle stepper control package
// Payload, configuration and result types with their reset constants.
// ----------------------------------------------------------------------------
package gnsc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_DIVIDER   = 2'd0,
    CFG_SETPOINT_LIMIT = 2'd1,
    CFG_BLINK_PERIOD   = 2'd2,
    CFG_BLINK_ON_TIME  = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] STEP_DIVIDER_RST   = 8'd5;
  localparam logic [9:0] SETPOINT_LIMIT_RST = 10'd240;
  localparam logic [7:0] BLINK_PERIOD_RST   = 8'd199;
  localparam logic [7:0] BLINK_ON_TIME_RST  = 8'd100;
  localparam logic [9:0] SETPOINT_MAX       = 10'd999;

  typedef struct packed {
    logic              sw1_on;
    logic              sw2_on;
    logic signed [7:0] clicks;
  } in_t;

  typedef struct packed {
    logic        coil_a;
    logic        coil_b;
    logic [10:0] needle_angle;
    logic [9:0]  setpoint_value;
    logic [3:0]  digit_hundreds;
    logic [3:0]  digit_tens;
    logic [3:0]  digit_ones;
    logic        led_on;
  } out_t;

  typedef struct packed {
    logic [7:0] step_divider;
    logic [9:0] setpoint_limit;
    logic [7:0] blink_period;
    logic [7:0] blink_on_time;
  } cfg_t;

  typedef struct packed {
    logic        coil_a;
    logic        coil_b;
    logic [10:0] needle_angle;
    logic [9:0]  setpoint_value;
    logic        led_on;
  } res_t;

endpackage

FILE: rtl/gnsc_digits.sv
// ----------------------------------------------------------------------------
// Gauge needle stepper control decimal split
// Splits a value up to 999 into hundreds, tens and ones by reciprocal multiply.
// ----------------------------------------------------------------------------
module gnsc_digits (
  input  logic [9:0] value_i,
  output logic [3:0] hundreds_o,
  output logic [3:0] tens_o,
  output logic [3:0] ones_o
);

  logic [15:0] hund_prod;
  logic [9:0]  hund_sub;
  logic [9:0]  rem_full;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [6:0]  tens_sub;

  always_comb begin
    hund_prod  = {6'd0, value_i} * 16'd41;
    hundreds_o = hund_prod[15:12];
    hund_sub   = {6'd0, hundreds_o} * 10'd100;
    rem_full   = value_i - hund_sub;
    rem        = rem_full[6:0];
    tens_prod  = {8'd0, rem} * 15'd205;
    tens_o     = tens_prod[14:11];
    tens_sub   = {3'd0, tens_o} * 7'd10;
    ones_o     = 4'(rem - tens_sub);
  end

endmodule

FILE: rtl/gnsc_tick.sv
// ----------------------------------------------------------------------------
// Gauge needle stepper control tick engine
// Holds the setpoint, needle, move timer and blink counter, and works out
// one tick's result from the registered input item.
// ----------------------------------------------------------------------------
module gnsc_tick (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  gnsc_pkg::in_t  item_i,
  input  gnsc_pkg::cfg_t cfg_i,
  output gnsc_pkg::res_t res_o
);

  import gnsc_pkg::*;

  logic [9:0]         setpoint_q, setpoint_d;
  logic [10:0]        needle_q, needle_d;
  logic [7:0]         move_timer_q, move_timer_d;
  logic [7:0]         blink_count_q, blink_count_d;
  logic [10:0]        target;
  logic [9:0]         limit;
  logic signed [11:0] sum;
  logic               led;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q    <= '0;
      needle_q      <= '0;
      move_timer_q  <= '0;
      blink_count_q <= BLINK_PERIOD_RST;
    end else if (step_i) begin
      setpoint_q    <= setpoint_d;
      needle_q      <= needle_d;
      move_timer_q  <= move_timer_d;
      blink_count_q <= blink_count_d;
    end
  end

  always_comb begin
    target = (item_i.sw1_on && !item_i.sw2_on) ? {setpoint_q, 1'b0} : '0;

    needle_d = needle_q;
    if (move_timer_q < cfg_i.step_divider) begin
      move_timer_d = move_timer_q + 8'd1;
    end else begin
      move_timer_d = '0;
      if (target > needle_q) begin
        needle_d = needle_q + 11'd1;
      end else if (target < needle_q) begin
        needle_d = needle_q - 11'd1;
      end
    end

    if (!item_i.sw1_on) begin
      blink_count_d = cfg_i.blink_period;
      led           = 1'b0;
    end else begin
      if (blink_count_q < cfg_i.blink_period) begin
        blink_count_d = blink_count_q + 8'd1;
      end else begin
        blink_count_d = '0;
      end
      led = (blink_count_d < cfg_i.blink_on_time);
    end

    limit = (cfg_i.setpoint_limit > SETPOINT_MAX) ? SETPOINT_MAX : cfg_i.setpoint_limit;
    sum   = $signed({2'b00, setpoint_q}) + $signed({{4{item_i.clicks[7]}}, item_i.clicks});
    if (sum[11]) begin
      setpoint_d = '0;
    end else if (sum[10:0] > {1'b0, limit}) begin
      setpoint_d = limit;
    end else begin
      setpoint_d = sum[9:0];
    end

    res_o.coil_a         = needle_d[1];
    res_o.coil_b         = needle_d[1] ^ needle_d[0];
    res_o.needle_angle   = needle_d;
    res_o.setpoint_value = setpoint_d;
    res_o.led_on         = led;
  end

endmodule

FILE: rtl/gauge_needle_stepper_control.sv
// ----------------------------------------------------------------------------
// Gauge needle stepper control
// One item per 5 ms tick: setpoint adjust and clamp, needle stepping toward
// its target, stepper phase lines, decimal digits and a blink LED.
// ----------------------------------------------------------------------------
// The input channel takes one tick item (switch states and signed encoder
// clicks) on each edge with in_valid_i high and in_stall_o low; the item
// lands in an input register. When the output register is free or being
// emptied, the tick state is updated and the result is written to the
// output register, which is offered on out_valid_o / out_data_o until a
// transfer with out_stall_i low. One item is taken every cycle while the
// receiver keeps up. Because the input and output registers are separate,
// a new item is still taken while a result waits; a second one is held off
// only while both registers are full.
// The configuration port writes one register per cycle with cfg_we_i and
// should be used only while the block is idle.
// Reset clears both valid flags, the setpoint, needle and move timer, loads
// the blink counter with its period and the registers with their defaults.
// ----------------------------------------------------------------------------
module gauge_needle_stepper_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gnsc_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gnsc_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gnsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gnsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  import gnsc_pkg::*;

`include "gauge_needle_stepper_control_assert.svh"

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  res_t res_q;
  res_t res_d;
  cfg_t cfg_q;
  logic advance;
  logic [3:0] hundreds, tens, ones;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_divider   <= STEP_DIVIDER_RST;
      cfg_q.setpoint_limit <= SETPOINT_LIMIT_RST;
      cfg_q.blink_period   <= BLINK_PERIOD_RST;
      cfg_q.blink_on_time  <= BLINK_ON_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_STEP_DIVIDER:   cfg_q.step_divider   <= cfg_wdata_i[7:0];
        CFG_SETPOINT_LIMIT: cfg_q.setpoint_limit <= cfg_wdata_i;
        CFG_BLINK_PERIOD:   cfg_q.blink_period   <= cfg_wdata_i[7:0];
        CFG_BLINK_ON_TIME:  cfg_q.blink_on_time  <= cfg_wdata_i[7:0];
      endcase
    end
  end

  gnsc_tick u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  gnsc_digits u_digits (
    .value_i    (res_q.setpoint_value),
    .hundreds_o (hundreds),
    .tens_o     (tens),
    .ones_o     (ones)
  );

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.coil_a         = res_q.coil_a;
    out_data_o.coil_b         = res_q.coil_b;
    out_data_o.needle_angle   = res_q.needle_angle;
    out_data_o.setpoint_value = res_q.setpoint_value;
    out_data_o.digit_hundreds = hundreds;
    out_data_o.digit_tens     = tens;
    out_data_o.digit_ones     = ones;
    out_data_o.led_on         = res_q.led_on;
  end

  `GNSC_ASSERT_SAME(a_setpoint_bound, out_valid_o, out_data_o.setpoint_value <= SETPOINT_MAX, "setpoint above 999")
  `GNSC_ASSERT_SAME(a_digits_decimal, out_valid_o, (out_data_o.digit_tens < 4'd10) && (out_data_o.digit_ones < 4'd10), "digit not decimal")
  `GNSC_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i && in_valid_q, "input stalled without a blocked result")
  `GNSC_ASSERT_NEXT(a_result_follows, advance, out_valid_o, "result not presented after a tick")

endmodule
